// ===== sv/csn_pkg.sv =====
// shared constants, types and register indexes of the color sample normalizer
// no dependencies

package csn_pkg;

  localparam int ChanW      = 2;
  localparam int SampleW    = 10;
  localparam int SumW       = 15;
  localparam int CountW     = 5;
  localparam int LevelW     = 8;
  localparam int NumRegs    = 6;
  localparam int RegIdxW    = 3;
  // dividend of the shared divider: magnitude of (average - black) * 255
  localparam int DivW       = SampleW + LevelW + 1;
  localparam int QDepth     = 2;

  localparam int SamplesPerReadingDef = 20;

  localparam logic [LevelW-1:0] FullScale = 8'd255;

  localparam logic [ChanW-1:0] ChanRed   = 2'd0;
  localparam logic [ChanW-1:0] ChanGreen = 2'd1;
  localparam logic [ChanW-1:0] ChanBlue  = 2'd2;

  localparam logic [RegIdxW-1:0] RegRedWhite   = 3'd0;
  localparam logic [RegIdxW-1:0] RegRedBlack   = 3'd1;
  localparam logic [RegIdxW-1:0] RegGreenWhite = 3'd2;
  localparam logic [RegIdxW-1:0] RegGreenBlack = 3'd3;
  localparam logic [RegIdxW-1:0] RegBlueWhite  = 3'd4;
  localparam logic [RegIdxW-1:0] RegBlueBlack  = 3'd5;

  typedef logic [NumRegs-1:0][SampleW-1:0] cal_regs_t;

  // element 0 is the lowest slice
  localparam cal_regs_t CalReset = {10'd0, 10'd1023, 10'd0, 10'd1023, 10'd0, 10'd1023};

  typedef struct packed {
    logic [ChanW-1:0] chan;
    logic [SumW-1:0]  sum;
  } burst_t;

  typedef struct packed {
    logic               start;
    logic [DivW-1:0]    dividend;
    logic [SampleW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic [ChanW-1:0]   chan;
    logic [SampleW-1:0] avg;
    logic [LevelW-1:0]  level;
    logic               clipped;
    logic               bad;
  } result_t;

endpackage

// ===== sv/csn_if.sv =====
// valid/ready channel interfaces of the color sample normalizer
// depends on csn_pkg for field widths

interface csn_sample_if;
  logic                           valid;
  logic                           ready;
  logic [csn_pkg::ChanW-1:0]      channel;
  logic [csn_pkg::SampleW-1:0]    sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface csn_result_if;
  logic                           valid;
  logic                           ready;
  logic [csn_pkg::ChanW-1:0]      out_channel;
  logic [csn_pkg::SampleW-1:0]    average;
  logic [csn_pkg::LevelW-1:0]     level;
  logic                           clipped;
  logic                           bad_calibration;

  modport source (output valid, output out_channel, output average, output level,
                  output clipped, output bad_calibration, input ready);
  modport sink   (input valid, input out_channel, input average, input level,
                  input clipped, input bad_calibration, output ready);
endinterface

interface csn_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [csn_pkg::RegIdxW-1:0]    index;
  logic [csn_pkg::SampleW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/color_sample_normalizer.sv =====
// Color sample normalizer: a sample enters every cycle while the burst is running, except that
// a burst end waits while the two-deep queue of finished bursts is full. The back part takes a
// burst from the queue and forms the average by a reciprocal multiply in that cycle, then checks
// the calibration and starts the one-bit-per-cycle level divider (or skips it on bad
// calibration), picks up the quotient, registers the result and presents it; it takes the next
// burst in the cycle after the result transfer, so it holds one burst at a time. Calibration
// registers are write-only through the config channel, always ready, indexes above five are
// dropped.
// depends on csn_pkg, csn_if, csn_front, csn_fifo, csn_back

module color_sample_normalizer #(
  parameter int SamplesPerReading = csn_pkg::SamplesPerReadingDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  csn_sample_if.sink   sample_i,
  csn_result_if.source result_o,
  csn_cfg_if.sink      cfg_i
);

  csn_pkg::cal_regs_t cal_q;
  logic               push;
  csn_pkg::burst_t    push_data;
  logic               full;
  logic               pop;
  logic               q_valid;
  csn_pkg::burst_t    q_data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= csn_pkg::CalReset;
    end else if (cfg_i.valid && (cfg_i.index < csn_pkg::RegIdxW'(csn_pkg::NumRegs))) begin
      cal_q[cfg_i.index] <= cfg_i.data;
    end
  end

  csn_front #(
    .SamplesPerReading (SamplesPerReading)
  ) u_front (
    .clk_i,
    .rst_ni,
    .sample_i,
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  csn_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  csn_back #(
    .SamplesPerReading (SamplesPerReading)
  ) u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_pop_o   (pop),
    .cal_i     (cal_q),
    .result_o
  );

endmodule

// ===== sv/csn_front.sv =====
// front part: accepts samples, accumulates the burst sum and count
// depends on csn_pkg, csn_if; pushes finished bursts into the queue

module csn_front #(
  parameter int SamplesPerReading = csn_pkg::SamplesPerReadingDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  csn_sample_if.sink      sample_i,
  output logic            push_o,
  output csn_pkg::burst_t push_data_o,
  input  logic            full_i
);

  localparam logic [csn_pkg::CountW-1:0] LastCount = csn_pkg::CountW'(SamplesPerReading);

  logic [csn_pkg::SumW-1:0]   sum_q, sum_d, sum_next;
  logic [csn_pkg::CountW-1:0] count_q, count_d, count_next;
  logic                       last;
  logic                       accept;

  assign sum_next   = sum_q + csn_pkg::SumW'(sample_i.sample);
  assign count_next = count_q + 1'b1;
  assign last       = (count_next == LastCount);

  // a burst end needs a free queue slot, any other sample goes straight in
  assign sample_i.ready = !(last && full_i);
  assign accept         = sample_i.valid && sample_i.ready;

  assign push_o           = accept && last;
  assign push_data_o.chan = sample_i.channel;
  assign push_data_o.sum  = sum_next;

  always_comb begin
    sum_d   = sum_q;
    count_d = count_q;
    if (accept) begin
      if (last) begin
        sum_d   = '0;
        count_d = '0;
      end else begin
        sum_d   = sum_next;
        count_d = count_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
    end else begin
      sum_q   <= sum_d;
      count_q <= count_d;
    end
  end

endmodule

// ===== sv/csn_fifo.sv =====
// short queue of finished bursts between the front and back parts
// depends on csn_pkg

module csn_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  csn_pkg::burst_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output csn_pkg::burst_t pop_data_o
);

  localparam int PtrW = (csn_pkg::QDepth > 1) ? $clog2(csn_pkg::QDepth) : 1;
  localparam int CntW = $clog2(csn_pkg::QDepth + 1);

  csn_pkg::burst_t mem_q [csn_pkg::QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(csn_pkg::QDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(csn_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(csn_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== sv/csn_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle, unsigned
// depends on csn_pkg; serves the level division of the back part

module csn_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  csn_pkg::div_req_t req_i,
  output csn_pkg::div_rsp_t rsp_o
);

  localparam int DivW = csn_pkg::DivW;
  localparam int CntW = $clog2(DivW);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic [DivW-1:0]             dvd_q, dvd_d;
  logic [csn_pkg::SampleW-1:0] rem_q, rem_d;
  logic [csn_pkg::SampleW-1:0] dvs_q, dvs_d;
  logic [csn_pkg::SampleW:0]   trial;
  logic                        fits;

  // dividend shifts out at the top while quotient bits shift in at the bottom
  assign trial = {rem_q, dvd_q[DivW-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (busy_q) begin
      rem_d = fits ? csn_pkg::SampleW'(trial - {1'b0, dvs_q})
                   : trial[csn_pkg::SampleW-1:0];
      dvd_d = {dvd_q[DivW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

// ===== sv/csn_back.sv =====
// back part: averages a burst and scales it against the calibration registers
// depends on csn_pkg, csn_if, csn_div

module csn_back #(
  parameter int SamplesPerReading = csn_pkg::SamplesPerReadingDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  csn_pkg::burst_t    q_data_i,
  output logic               q_pop_o,
  input  csn_pkg::cal_regs_t cal_i,
  csn_result_if.source       result_o
);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SScale = 3'd2;
  localparam logic [2:0] SLvl   = 3'd3;
  localparam logic [2:0] SOut   = 3'd4;

  localparam int RecipShift = csn_pkg::SumW + csn_pkg::CountW;
  localparam int RecipW     = RecipShift + 1;
  localparam int ProdW      = csn_pkg::SumW + RecipW;
  // reciprocal of the burst length rounded up, exact for every 15-bit sum
  localparam logic [RecipW-1:0] AvgRecip =
    RecipW'((2 ** RecipShift + SamplesPerReading - 1) / SamplesPerReading);

  logic [2:0]                  state_q, state_d;
  csn_pkg::result_t            res_q, res_d;
  logic                        neg_q, neg_d;
  csn_pkg::div_req_t           div_req;
  csn_pkg::div_rsp_t           div_rsp;

  logic [csn_pkg::SampleW-1:0] white, black;
  logic                        no_cal;
  logic signed [csn_pkg::SampleW:0]   diff_s, span_s;
  logic signed [csn_pkg::DivW:0]      num_s;
  logic [csn_pkg::DivW-1:0]           num_mag;
  logic [csn_pkg::SampleW-1:0]        span_mag;
  logic [csn_pkg::DivW-1:0]           quot;
  logic [ProdW-1:0]                   avg_prod;

  csn_div u_div (
    .clk_i,
    .rst_ni,
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // burst average as a multiply by the reciprocal and a shift
  assign avg_prod = ProdW'(q_data_i.sum) * ProdW'(AvgRecip);

  // calibration pair of the burst's channel
  always_comb begin
    white  = '0;
    black  = '0;
    no_cal = 1'b0;
    case (res_q.chan)
      csn_pkg::ChanRed: begin
        white = cal_i[csn_pkg::RegRedWhite];
        black = cal_i[csn_pkg::RegRedBlack];
      end
      csn_pkg::ChanGreen: begin
        white = cal_i[csn_pkg::RegGreenWhite];
        black = cal_i[csn_pkg::RegGreenBlack];
      end
      csn_pkg::ChanBlue: begin
        white = cal_i[csn_pkg::RegBlueWhite];
        black = cal_i[csn_pkg::RegBlueBlack];
      end
      default: begin
        no_cal = 1'b1;
      end
    endcase
  end

  // (avg - black) * 255 as shift and subtract, then sign and magnitude
  assign diff_s   = $signed({1'b0, res_q.avg}) - $signed({1'b0, black});
  assign span_s   = $signed({1'b0, white}) - $signed({1'b0, black});
  assign num_s    = ((csn_pkg::DivW + 1)'(diff_s) <<< csn_pkg::LevelW)
                    - (csn_pkg::DivW + 1)'(diff_s);
  assign num_mag  = num_s[csn_pkg::DivW] ? csn_pkg::DivW'(-num_s)
                                         : num_s[csn_pkg::DivW-1:0];
  assign span_mag = span_s[csn_pkg::SampleW] ? csn_pkg::SampleW'(-span_s)
                                             : span_s[csn_pkg::SampleW-1:0];
  assign quot     = div_rsp.quotient;

  always_comb begin
    state_d          = state_q;
    res_d            = res_q;
    neg_d            = neg_q;
    q_pop_o          = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = num_mag;
    div_req.divisor  = span_mag;
    case (state_q)
      SIdle: begin
        if (q_valid_i) begin
          q_pop_o    = 1'b1;
          res_d.chan = q_data_i.chan;
          res_d.avg  = avg_prod[RecipShift +: csn_pkg::SampleW];
          state_d    = SScale;
        end
      end
      SScale: begin
        res_d.level   = '0;
        res_d.clipped = 1'b0;
        res_d.bad     = 1'b0;
        if (no_cal || (span_s == '0)) begin
          res_d.bad = 1'b1;
          state_d   = SOut;
        end else begin
          div_req.start = 1'b1;
          neg_d         = num_s[csn_pkg::DivW] ^ span_s[csn_pkg::SampleW];
          state_d       = SLvl;
        end
      end
      SLvl: begin
        if (div_rsp.done) begin
          // a zero quotient is not negative even when the signs differ
          if (quot == '0) begin
            res_d.level = '0;
          end else if (neg_q) begin
            res_d.level   = '0;
            res_d.clipped = 1'b1;
          end else if (quot > csn_pkg::DivW'(csn_pkg::FullScale)) begin
            res_d.level   = csn_pkg::FullScale;
            res_d.clipped = 1'b1;
          end else begin
            res_d.level = quot[csn_pkg::LevelW-1:0];
          end
          state_d = SOut;
        end
      end
      SOut: begin
        if (result_o.ready) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    neg_q <= neg_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign result_o.valid           = (state_q == SOut);
  assign result_o.out_channel     = res_q.chan;
  assign result_o.average         = res_q.avg;
  assign result_o.level           = res_q.level;
  assign result_o.clipped         = res_q.clipped;
  assign result_o.bad_calibration = res_q.bad;

`ifndef SYNTH
  a_bad_no_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.bad_calibration |->
      result_o.level == '0 && !result_o.clipped)
    else $error("bad calibration with nonzero level or clip");

  a_clip_rails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.clipped |->
      result_o.level == '0 || result_o.level == csn_pkg::FullScale)
    else $error("clipped level not at a rail");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == SLvl)
    else $error("divider finished while back part not waiting");

  a_pop_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> state_q == SScale && !div_rsp.busy)
    else $error("burst popped while the divider was still busy");
`endif

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench of color_sample_normalizer: directed bursts, then random phases
// with recalibration, idling, stalls and a long receiver hold-off
// depends on csn_pkg, csn_if and the normalizer rtl

module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int Burst       = csn_pkg::SamplesPerReadingDef;
  localparam int SettleCycles = 100;
  localparam int HoldCycles  = 500;
  localparam int StuckLimit  = 4000;
  localparam int PhaseItems  = 250;
  localparam int NumPhases   = 8;

  // channel code with no calibration registers behind it
  localparam logic [csn_pkg::ChanW-1:0]   ChanNone   = 2'd3;
  localparam logic [csn_pkg::RegIdxW-1:0] RegUnused6 = 3'd6;
  localparam logic [csn_pkg::RegIdxW-1:0] RegUnused7 = 3'd7;

  typedef enum {RowBurst, RowWrite} row_kind_e;
  typedef enum {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  // a burst row sends Burst copies of data on channel ch; idx only matters for writes
  typedef struct {
    row_kind_e                    kind;
    logic [csn_pkg::RegIdxW-1:0]  idx;
    logic [csn_pkg::SampleW-1:0]  data;
    logic [csn_pkg::ChanW-1:0]    ch;
    bit                           typed;
    logic [csn_pkg::LevelW-1:0]   level;
    bit                           clip;
    bit                           bad;
  } row_t;

  row_t plan [18] = '{
    '{RowBurst, csn_pkg::RegRedWhite,   10'd0,    csn_pkg::ChanRed,   1'b1, 8'd0,   1'b0, 1'b0},
    '{RowBurst, csn_pkg::RegRedWhite,   10'd1023, csn_pkg::ChanGreen, 1'b1, 8'd255, 1'b0, 1'b0},
    '{RowBurst, csn_pkg::RegRedWhite,   10'd512,  csn_pkg::ChanBlue,  1'b0, 8'd0,   1'b0, 1'b0},
    '{RowBurst, csn_pkg::RegRedWhite,   10'd700,  ChanNone,           1'b1, 8'd0,   1'b0, 1'b1},
    '{RowWrite, csn_pkg::RegRedWhite,   10'd300,  csn_pkg::ChanRed,   1'b0, 8'd0,   1'b0, 1'b0},
    '{RowWrite, csn_pkg::RegRedBlack,   10'd300,  csn_pkg::ChanRed,   1'b0, 8'd0,   1'b0, 1'b0},
    '{RowWrite, csn_pkg::RegGreenWhite, 10'd100,  csn_pkg::ChanRed,   1'b0, 8'd0,   1'b0, 1'b0},
    '{RowWrite, csn_pkg::RegGreenBlack, 10'd900,  csn_pkg::ChanRed,   1'b0, 8'd0,   1'b0, 1'b0},
    '{RowWrite, csn_pkg::RegBlueWhite,  10'd800,  csn_pkg::ChanRed,   1'b0, 8'd0,   1'b0, 1'b0},
    '{RowWrite, csn_pkg::RegBlueBlack,  10'd200,  csn_pkg::ChanRed,   1'b0, 8'd0,   1'b0, 1'b0},
    '{RowWrite, RegUnused7,             10'd0,    csn_pkg::ChanRed,   1'b0, 8'd0,   1'b0, 1'b0},
    '{RowBurst, csn_pkg::RegRedWhite,   10'd1023, csn_pkg::ChanRed,   1'b1, 8'd0,   1'b0, 1'b1},
    '{RowBurst, csn_pkg::RegRedWhite,   10'd0,    csn_pkg::ChanGreen, 1'b0, 8'd0,   1'b0, 1'b0},
    '{RowBurst, csn_pkg::RegRedWhite,   10'd1023, csn_pkg::ChanGreen, 1'b0, 8'd0,   1'b0, 1'b0},
    '{RowBurst, csn_pkg::RegRedWhite,   10'd100,  csn_pkg::ChanBlue,  1'b0, 8'd0,   1'b0, 1'b0},
    '{RowBurst, csn_pkg::RegRedWhite,   10'd1023, csn_pkg::ChanBlue,  1'b0, 8'd0,   1'b0, 1'b0},
    '{RowBurst, csn_pkg::RegRedWhite,   10'd500,  csn_pkg::ChanBlue,  1'b0, 8'd0,   1'b0, 1'b0},
    '{RowBurst, csn_pkg::RegRedWhite,   10'd0,    ChanNone,           1'b1, 8'd0,   1'b0, 1'b1}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  csn_sample_if sample_if ();
  csn_result_if result_if ();
  csn_cfg_if    cfg_if ();

  color_sample_normalizer dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // shadow of the calibration registers and of the running burst
  csn_pkg::cal_regs_t cal = csn_pkg::CalReset;
  int                 burst_sum = 0;
  int                 burst_cnt = 0;
  csn_pkg::result_t   readings_due [$];
  bit                 use_typed = 1'b0;
  csn_pkg::result_t   typed_res;

  int mismatches    = 0;
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int results_taken = 0;
  int hold_at       = -1;
  int hold_left     = 0;
  int stuck_cycles  = 0;
  csn_pkg::result_t want;

  function automatic csn_pkg::result_t scaled_reading(logic [csn_pkg::ChanW-1:0] ch,
                                                      logic [csn_pkg::SampleW-1:0] avg);
    csn_pkg::result_t r;
    int               white, black, span, q;
    r = '0;
    r.chan = ch;
    r.avg  = avg;
    if (ch > csn_pkg::ChanBlue) begin
      r.bad = 1'b1;
    end else begin
      white = int'(cal[2*ch]);
      black = int'(cal[2*ch+1]);
      span  = white - black;
      if (span == 0) begin
        r.bad = 1'b1;
      end else begin
        // int division truncates toward zero, also for a negative span
        q = ((int'(avg) - black) * int'(csn_pkg::FullScale)) / span;
        if (q < 0) begin
          r.clipped = 1'b1;
        end else if (q > int'(csn_pkg::FullScale)) begin
          r.level   = csn_pkg::FullScale;
          r.clipped = 1'b1;
        end else begin
          r.level = csn_pkg::LevelW'(q);
        end
      end
    end
    return r;
  endfunction

  task automatic report(input string what, input int got, input int exp_val);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, exp_val);
    mismatches++;
  endtask

  // predictor: register writes and sample transfers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready && cfg_if.index < csn_pkg::NumRegs)
        cal[cfg_if.index] = cfg_if.data;
      if (sample_if.valid && sample_if.ready) begin
        burst_sum = burst_sum + int'(sample_if.sample);
        burst_cnt++;
        if (burst_cnt == Burst) begin
          if (use_typed) begin
            readings_due.push_back(typed_res);
            use_typed = 1'b0;
          end else begin
            readings_due.push_back(scaled_reading(sample_if.channel,
                                                  csn_pkg::SampleW'(burst_sum / Burst)));
          end
          burst_sum = 0;
          burst_cnt = 0;
        end
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (readings_due.size() == 0) begin
        report("unexpected result, channel", int'(result_if.out_channel), -1);
      end else begin
        want = readings_due.pop_front();
        if (result_if.out_channel !== want.chan)
          report("out_channel", int'(result_if.out_channel), int'(want.chan));
        if (result_if.average !== want.avg)
          report("average", int'(result_if.average), int'(want.avg));
        if (result_if.level !== want.level)
          report("level", int'(result_if.level), int'(want.level));
        if (result_if.clipped !== want.clipped)
          report("clipped", int'(result_if.clipped), int'(want.clipped));
        if (result_if.bad_calibration !== want.bad)
          report("bad_calibration", int'(result_if.bad_calibration), int'(want.bad));
      end
    end
  end

  // receiver: random stalls plus one long hold-off after a chosen result
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        results_taken++;
        if (results_taken == hold_at)
          hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= StuckLimit) begin
        $display("timeout: no transfer for %0d cycles", stuck_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic put_sample(input logic [csn_pkg::ChanW-1:0] ch,
                            input logic [csn_pkg::SampleW-1:0] smp);
    while ($urandom_range(99) < src_idle_pct) begin
      sample_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_if.valid   <= 1'b1;
    sample_if.channel <= ch;
    sample_if.sample  <= smp;
    @(posedge clk_i);
    while (!sample_if.ready) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [csn_pkg::RegIdxW-1:0] idx,
                         input logic [csn_pkg::SampleW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  // stop offering samples and wait until every result is out and the back end is quiet
  task automatic drain();
    sample_if.valid <= 1'b0;
    @(posedge clk_i);
    while (readings_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_idling(input idle_mode_e mode);
    src_idle_pct  = (mode == IdleSender) ? 86 : (mode == IdleBoth) ? 34 : 0;
    snk_stall_pct = (mode == IdleReceiver) ? 86 : (mode == IdleBoth) ? 34 : 0;
  endtask

  task automatic calibrate(input int phase);
    logic [csn_pkg::RegIdxW-1:0] white_reg [3];
    logic [csn_pkg::RegIdxW-1:0] black_reg [3];
    int                          sel, w, b;
    white_reg = '{csn_pkg::RegRedWhite, csn_pkg::RegGreenWhite, csn_pkg::RegBlueWhite};
    black_reg = '{csn_pkg::RegRedBlack, csn_pkg::RegGreenBlack, csn_pkg::RegBlueBlack};
    for (int c = 0; c < 3; c++) begin
      sel = (phase < 3) ? phase : $urandom_range(0, 4);
      case (sel)
        0: begin
          w = 1023;
          b = 0;
        end
        1: begin
          w = 0;
          b = 1023;
        end
        2: begin
          w = $urandom_range(0, 1023);
          b = w;
        end
        3: begin
          b = $urandom_range(0, 600);
          w = b + $urandom_range(1, 423);
        end
        default: begin
          w = $urandom_range(0, 1023);
          b = $urandom_range(0, 1023);
        end
      endcase
      put_reg(white_reg[c], csn_pkg::SampleW'(w));
      put_reg(black_reg[c], csn_pkg::SampleW'(b));
    end
    put_reg($urandom_range(0, 1) ? RegUnused6 : RegUnused7,
            csn_pkg::SampleW'($urandom_range(0, 1023)));
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    int                        base, spread, v, r;
    logic [csn_pkg::ChanW-1:0] burst_ch, ch;
    row_t                      row;

    sample_if.valid   = 1'b0;
    sample_if.channel = '0;
    sample_if.sample  = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
    result_if.ready   = 1'b0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed bursts and register writes
    set_idling(IdleNone);
    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == RowWrite) begin
        if (i == 0 || plan[i-1].kind != RowWrite)
          drain();
        put_reg(row.idx, row.data);
        if (i + 1 < $size(plan) && plan[i+1].kind != RowWrite)
          cfg_if.valid <= 1'b0;
      end else begin
        for (int k = 0; k < Burst; k++) begin
          // the last sample closes the burst: hand over a typed expectation if there is one
          if (k == Burst - 1 && row.typed) begin
            typed_res = '{chan: row.ch, avg: row.data, level: row.level,
                          clipped: row.clip, bad: row.bad};
            use_typed = 1'b1;
          end
          put_sample(row.ch, row.data);
        end
      end
    end

    // random phases, each with its own calibration and idling
    for (int p = 0; p < NumPhases; p++) begin
      drain();
      calibrate(p);
      set_idling(idle_mode_e'(p % 4));
      if (p == 2)
        hold_at = results_taken + 3;
      for (int n = 0; n < PhaseItems; n++) begin
        if (p == 5 && n == PhaseItems / 2) begin
          sample_if.valid <= 1'b0;
          @(posedge clk_i);
          while (readings_due.size() != 0) @(posedge clk_i);
        end
        if (burst_cnt == 0 || n == 0) begin
          base   = $urandom_range(0, 1023);
          spread = $urandom_range(0, 3);
          r      = $urandom_range(0, 9);
          burst_ch = (r == 9) ? ChanNone : csn_pkg::ChanW'(r % 3);
        end
        case (spread)
          0:       v = base;
          1:       v = base + $urandom_range(0, 15) - 8;
          2:       v = base + $urandom_range(0, 127) - 64;
          default: v = $urandom_range(0, 1023);
        endcase
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        ch = ($urandom_range(0, 7) == 0) ? csn_pkg::ChanW'($urandom_range(0, 3)) : burst_ch;
        put_sample(ch, csn_pkg::SampleW'(v));
      end
    end

    sample_if.valid <= 1'b0;
    @(posedge clk_i);
    while (readings_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
